// File: src/snps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// snps_pkg: shared types and constants of the spoken-number prompt sequencer
// Prompt numbers, divider reciprocals, the slot descriptor that travels from
// the front pipeline through the queue to the back sequencer.
// ----------------------------------------------------------------------------
package snps_pkg;

    localparam int unsigned PROMPT_W = 7;
    localparam int unsigned NSLOT    = 10;
    localparam int unsigned QDEPTH   = 2;

    // prompt numbers
    localparam logic [PROMPT_W-1:0] P_TENS     = 7'd20;
    localparam logic [PROMPT_W-1:0] P_HUNDRED  = 7'd28;
    localparam logic [PROMPT_W-1:0] P_THOUSAND = 7'd29;
    localparam logic [PROMPT_W-1:0] P_HOUR     = 7'd40;
    localparam logic [PROMPT_W-1:0] P_MINUTE   = 7'd41;
    localparam logic [PROMPT_W-1:0] P_SECOND   = 7'd42;
    localparam logic [PROMPT_W-1:0] P_AND      = 7'd47;
    localparam logic [PROMPT_W-1:0] P_MINUS    = 7'd48;
    localparam logic [PROMPT_W-1:0] UNITS_BASE = 7'd50;

    // constant divisors and their reciprocals (exact over the value ranges used)
    localparam logic [15:0] DIV_THOU  = 16'd1000;
    localparam logic [15:0] DIV_HOUR  = 16'd3600;
    localparam logic [11:0] DIV_HUND  = 12'd100;
    localparam logic [11:0] DIV_MIN   = 12'd60;
    localparam logic [16:0] RECIP_THOU = 17'd67109;  // 2^26 / 1000, rounded up
    localparam logic [16:0] RECIP_HOUR = 17'd74566;  // 2^28 / 3600, rounded up
    localparam logic [23:0] RECIP_HUND = 24'd41;     // 2^12 / 100, rounded up
    localparam logic [23:0] RECIP_MIN  = 24'd4370;   // 2^18 / 60, rounded up
    localparam int unsigned SH_THOU = 26;
    localparam int unsigned SH_HOUR = 28;
    localparam int unsigned SH_HUND = 12;
    localparam int unsigned SH_MIN  = 18;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] units;
    } t_split;

    // one item's prompts in fixed slot order; mask marks the slots spoken
    typedef struct packed {
        logic [NSLOT-1:0]               mask;
        logic [NSLOT-1:0][PROMPT_W-1:0] val;
    } t_desc;

    // split a value below 100 into tens and units digits
    function automatic t_split f_split(input logic [6:0] x);
        logic [14:0] prod;
        logic [3:0]  tq;
        logic [6:0]  tx;
        t_split      res;
        prod      = {8'b0, x} * 15'd205;
        tq        = prod[14:11];
        tx        = {3'b0, tq} * 7'd10;
        res.tens  = tq;
        res.units = 4'(x - tx);
        return res;
    endfunction

    // tens word prompt for a tens digit of two or more
    function automatic logic [PROMPT_W-1:0] f_tens_word(input logic [3:0] t);
        return P_TENS + {3'b0, t} - 7'd2;
    endfunction

endpackage
`default_nettype wire

// File: src/spoken_number_prompt_sequencer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spoken_number_prompt_sequencer_core: French spoken-number prompt sequencer
// Turns a signed value into the voice-prompt indices that speak it, either
// as a number with an optional unit word or as a duration in seconds.
// ----------------------------------------------------------------------------
// Each transfer on the input queue side (push/full) carries one value; the
// result side (empty/pop) hands out its prompts in play order, one per
// transfer, with o_last set on the final prompt of the value. A value has
// up to ten prompts, handed out one per cycle from the back end's single
// result register while it is empty or being popped, which sets the
// sustained rate. A new value may be pushed every cycle until the front
// pipeline and its two-entry descriptor queue fill up; from push, a value
// passes the front pipeline, the queue and the back end's slot registers
// on its way to the result ports. A zero duration produces no prompts
// at all. There is no configuration and nothing to clear after reset.
// ----------------------------------------------------------------------------
module spoken_number_prompt_sequencer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_command,
    input  logic signed [15:0]            i_value,
    input  logic [3:0]                    i_unit_code,
    output logic                          empty,
    input  logic                          pop,
    output logic [snps_pkg::PROMPT_W-1:0] o_prompt_index,
    output logic                          o_last
);
    import snps_pkg::*;

    // front to queue
    logic  w_f_push, w_q_full;
    t_desc w_f_desc;
    // queue to back
    logic  w_q_empty, w_q_pop;
    t_desc w_q_desc;

    // split the magnitude into thousands/hundreds/tens or hours/minutes/seconds
    snps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_command   (i_command),
        .i_value     (i_value),
        .i_unit_code (i_unit_code),
        .o_push      (w_f_push),
        .o_desc      (w_f_desc),
        .i_full      (w_q_full)
    );

    // hold finished descriptors while the back end drains earlier ones
    snps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_push),
        .i_desc  (w_f_desc),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_desc  (w_q_desc)
    );

    // advance through the marked slots, one prompt per transfer
    snps_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (w_q_empty),
        .o_q_pop        (w_q_pop),
        .i_desc         (w_q_desc),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_prompt_index (o_prompt_index),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire

// File: src/snps_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// snps_front: input pipeline of the prompt sequencer
// Takes the magnitude apart by constant division in five stages and builds
// the slot descriptor of one item.
// ----------------------------------------------------------------------------
module snps_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic                  i_command,
    input  logic signed [15:0]    i_value,
    input  logic [3:0]            i_unit_code,
    output logic                  o_push,
    output snps_pkg::t_desc       o_desc,
    input  logic                  i_full
);
    import snps_pkg::*;

    typedef struct packed {
        logic       cmd;
        logic       neg;
        logic [3:0] unit;
    } t_tag;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    t_tag r_tag1, r_tag2, r_tag3, r_tag4, r_tag5;
    logic [15:0] r_mag1, r_mag2;
    logic [5:0]  r_q1_2, r_q1_3, r_q1_4, r_q1_5;
    logic [11:0] r_r1_3, r_r1_4;
    logic [5:0]  r_q2_4, r_q2_5;
    logic [6:0]  r_r2_5;

    logic w_en1, w_en2, w_en3, w_en4, w_en5, w_fwd_ok;
    logic [32:0] w_p1;
    logic [5:0]  w_q1;
    logic [15:0] w_qc1;
    logic [23:0] w_p2;
    logic [5:0]  w_q2;
    logic [11:0] w_qc2;
    t_desc       w_desc;
    t_split      w_sp_q1, w_sp_q2, w_sp_r2;

    // stall chain: a stage takes new data when empty or when it moves on
    assign w_fwd_ok = (w_desc.mask == '0) || !i_full;
    assign w_en5    = !r_v5 || w_fwd_ok;
    assign w_en4    = !r_v4 || w_en5;
    assign w_en3    = !r_v3 || w_en4;
    assign w_en2    = !r_v2 || w_en3;
    assign w_en1    = !r_v1 || w_en2;
    assign o_full   = !w_en1;
    assign o_push   = r_v5 && (w_desc.mask != '0) && !i_full;
    assign o_desc   = w_desc;

    // first quotient: thousands or hours
    assign w_p1 = {17'b0, r_mag1} * {16'b0, (r_tag1.cmd ? RECIP_HOUR : RECIP_THOU)};
    assign w_q1 = r_tag1.cmd ? {2'b0, w_p1[SH_HOUR +: 4]} : w_p1[SH_THOU +: 6];

    assign w_qc1 = r_tag2.cmd ? ({10'b0, r_q1_2} * DIV_HOUR) : ({10'b0, r_q1_2} * DIV_THOU);

    // second quotient: hundreds or minutes
    assign w_p2 = {12'b0, r_r1_3} * (r_tag3.cmd ? RECIP_MIN : RECIP_HUND);
    assign w_q2 = r_tag3.cmd ? w_p2[SH_MIN +: 6] : {2'b0, w_p2[SH_HUND +: 4]};

    assign w_qc2 = r_tag4.cmd ? ({6'b0, r_q2_4} * DIV_MIN) : ({6'b0, r_q2_4} * DIV_HUND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_push;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_tag1.cmd  <= i_command;
            r_tag1.neg  <= i_value[15];
            r_tag1.unit <= i_unit_code;
            r_mag1      <= i_value[15] ? 16'(16'd0 - i_value) : i_value;
        end
        if (w_en2) begin
            r_tag2 <= r_tag1;
            r_mag2 <= r_mag1;
            r_q1_2 <= w_q1;
        end
        if (w_en3) begin
            r_tag3 <= r_tag2;
            r_q1_3 <= r_q1_2;
            r_r1_3 <= 12'(r_mag2 - w_qc1);
        end
        if (w_en4) begin
            r_tag4 <= r_tag3;
            r_q1_4 <= r_q1_3;
            r_r1_4 <= r_r1_3;
            r_q2_4 <= w_q2;
        end
        if (w_en5) begin
            r_tag5 <= r_tag4;
            r_q1_5 <= r_q1_4;
            r_q2_5 <= r_q2_4;
            r_r2_5 <= 7'(r_r1_4 - w_qc2);
        end
    end

    assign w_sp_q1 = f_split(7'(r_q1_5));
    assign w_sp_q2 = f_split(7'(r_q2_5));
    assign w_sp_r2 = f_split(r_r2_5);

    // slot build
    always_comb begin
        logic q1_ge20, q2_ge20, r2_ge20, spoken;
        logic [PROMPT_W-1:0] last_units;
        q1_ge20    = (r_q1_5 >= 6'd20);
        q2_ge20    = (r_q2_5 >= 6'd20);
        r2_ge20    = (r_r2_5 >= 7'd20);
        last_units = r2_ge20 ? {3'b0, w_sp_r2.units} : r_r2_5;
        spoken     = (r_q1_5 != '0) || (r_q2_5 != '0) || r2_ge20;

        w_desc        = '0;
        w_desc.mask[0] = r_tag5.neg;
        w_desc.val[0]  = P_MINUS;
        if (!r_tag5.cmd) begin
            // thousands count, thousand, hundreds digit, hundred, tens, units, unit
            w_desc.mask[1] = q1_ge20;
            w_desc.val[1]  = f_tens_word(w_sp_q1.tens);
            w_desc.mask[2] = (r_q1_5 >= 6'd2) && (!q1_ge20 || (w_sp_q1.units != '0));
            w_desc.val[2]  = q1_ge20 ? {3'b0, w_sp_q1.units} : 7'(r_q1_5);
            w_desc.mask[3] = (r_q1_5 != '0);
            w_desc.val[3]  = P_THOUSAND;
            w_desc.mask[4] = (r_q2_5 >= 6'd2);
            w_desc.val[4]  = 7'(r_q2_5);
            w_desc.mask[5] = (r_q2_5 != '0);
            w_desc.val[5]  = P_HUNDRED;
            w_desc.mask[6] = r2_ge20;
            w_desc.val[6]  = f_tens_word(w_sp_r2.tens);
            w_desc.mask[7] = (last_units != '0) || !spoken;
            w_desc.val[7]  = last_units;
            w_desc.mask[8] = (r_tag5.unit != '0);
            w_desc.val[8]  = UNITS_BASE + {3'b0, r_tag5.unit} - 7'd1;
        end else begin
            // hours, hour, minutes, minute, and, seconds, second
            w_desc.mask[1] = (r_q1_5 != '0);
            w_desc.val[1]  = 7'(r_q1_5);
            w_desc.mask[2] = (r_q1_5 != '0);
            w_desc.val[2]  = P_HOUR;
            w_desc.mask[3] = q2_ge20;
            w_desc.val[3]  = f_tens_word(w_sp_q2.tens);
            w_desc.mask[4] = (r_q2_5 != '0) && (!q2_ge20 || (w_sp_q2.units != '0));
            w_desc.val[4]  = q2_ge20 ? {3'b0, w_sp_q2.units} : 7'(r_q2_5);
            w_desc.mask[5] = (r_q2_5 != '0);
            w_desc.val[5]  = P_MINUTE;
            w_desc.mask[6] = (r_q2_5 != '0) && (r_r2_5 != '0);
            w_desc.val[6]  = P_AND;
            w_desc.mask[7] = r2_ge20;
            w_desc.val[7]  = f_tens_word(w_sp_r2.tens);
            w_desc.mask[8] = (r_r2_5 != '0) && (!r2_ge20 || (w_sp_r2.units != '0));
            w_desc.val[8]  = last_units;
            w_desc.mask[9] = (r_r2_5 != '0);
            w_desc.val[9]  = P_SECOND;
        end
        if (!r_v5) begin
            w_desc.mask = '0;
        end
    end

endmodule
`default_nettype wire

// File: src/snps_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// snps_queue: short descriptor queue
// Decouples the front pipeline from the back sequencer.
// ----------------------------------------------------------------------------
module snps_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  snps_pkg::t_desc i_desc,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output snps_pkg::t_desc o_desc
);
    import snps_pkg::*;

    localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

    t_desc              r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wptr, r_rptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_wr, w_rd;

    assign o_full  = (r_count == CNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_desc  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

endmodule
`default_nettype wire

// File: src/snps_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// snps_back: prompt sequencer back end
// Walks the marked slots of one descriptor, one prompt per cycle while the
// result register is empty or being popped, into the result register.
// ----------------------------------------------------------------------------
module snps_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    output logic                          o_q_pop,
    input  snps_pkg::t_desc               i_desc,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [snps_pkg::PROMPT_W-1:0] o_prompt_index,
    output logic                          o_last
);
    import snps_pkg::*;

    logic                          r_busy;
    logic [NSLOT-1:0]              r_mask;
    logic [NSLOT-1:0][PROMPT_W-1:0] r_vals;
    logic                          r_out_v;
    logic [PROMPT_W-1:0]           r_out_prompt;
    logic                          r_out_last;

    logic                w_out_free, w_emit, w_done, w_load;
    logic [NSLOT-1:0]    w_low, w_rest;
    logic [PROMPT_W-1:0] w_sel;

    assign w_out_free = !r_out_v || i_pop;
    assign w_emit     = r_busy && w_out_free;
    assign w_low      = r_mask & (~r_mask + 1'b1);
    assign w_rest     = r_mask & ~w_low;
    assign w_done     = w_emit && (w_rest == '0);
    assign w_load     = !i_q_empty && (!r_busy || w_done);
    assign o_q_pop    = w_load;

    always_comb begin
        w_sel = '0;
        for (int k = 0; k < NSLOT; k++) begin
            if (w_low[k]) w_sel = w_sel | r_vals[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_emit) begin
                r_out_v <= 1'b1;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mask <= i_desc.mask;
            r_vals <= i_desc.val;
        end else if (w_emit) begin
            r_mask <= w_rest;
        end
        if (w_emit) begin
            r_out_prompt <= w_sel;
            r_out_last   <= (w_rest == '0);
        end
    end

    assign o_empty        = !r_out_v;
    assign o_prompt_index = r_out_prompt;
    assign o_last         = r_out_last;

endmodule
`default_nettype wire

// File: test/tb_spoken_number_prompt_sequencer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_spoken_number_prompt_sequencer_core: self-checking bench of the sequencer
// Drives numbers and durations into the input queue side and compares every
// prompt popped from the result side with a prompt list spelled in the bench.
// The stimulus covers directed edge values, random traffic under several
// idling mixes, a long receiver hold-off that fills the block, and drains.
// ----------------------------------------------------------------------------
module tb_spoken_number_prompt_sequencer_core;
    import snps_pkg::*;

    localparam bit CMD_NUMBER   = 1'b0;
    localparam bit CMD_DURATION = 1'b1;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_PROMPTS  = 10;

    typedef struct {
        logic [PROMPT_W-1:0] prompt;
        logic                last;
    } t_prompt;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic                i_command = 1'b0;
    logic signed [15:0]  i_value = '0;
    logic [3:0]          i_unit_code = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic [PROMPT_W-1:0] o_prompt_index;
    logic                o_last;

    spoken_number_prompt_sequencer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_command      (i_command),
        .i_value        (i_value),
        .i_unit_code    (i_unit_code),
        .empty          (empty),
        .pop            (pop),
        .o_prompt_index (o_prompt_index),
        .o_last         (o_last)
    );

    logic [PROMPT_W-1:0] word_list[$];
    t_prompt             expected_prompts[$];

    int errors = 0;
    int items_sent = 0;
    int prompts_checked = 0;
    int full_stall_cycles = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #1600000;
        $display("%0t timeout with %0d prompts outstanding", $time, expected_prompts.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- predictor
    function automatic void add_word(input int unsigned w);
        if (word_list.size() < MAX_PROMPTS)
            word_list.push_back(PROMPT_W'(w));
    endfunction

    function automatic void say_below_thousand(input int unsigned m, input bit spoken);
        int unsigned r;
        bit          said;
        r    = m;
        said = spoken;
        if (r >= 100) begin
            if (r >= 200)
                add_word(r / 100);
            add_word(P_HUNDRED);
            r    = r % 100;
            said = 1'b1;
        end
        if (r >= 20) begin
            add_word(P_TENS + (r - 20) / 10);
            r    = r % 10;
            said = 1'b1;
        end
        if (r != 0 || !said)
            add_word(r);
    endfunction

    function automatic void say_count(input int unsigned m);
        int unsigned r;
        bit          said;
        r    = m;
        said = 1'b0;
        if (r >= 1000) begin
            // the count before "thousand" is voiced only from two thousand up
            if (r >= 2000)
                say_below_thousand(r / 1000, 1'b0);
            add_word(P_THOUSAND);
            r    = r % 1000;
            said = 1'b1;
        end
        say_below_thousand(r, said);
    endfunction

    // spell one item and queue its prompts, flagging the final one
    function automatic void spell_item(input bit cmd, input logic [15:0] raw,
                                       input logic [3:0] unit);
        int unsigned mag;
        int unsigned hrs;
        int unsigned mins;
        int unsigned secs;
        t_prompt     p;
        word_list.delete();
        mag = raw[15] ? (32'd65536 - {16'b0, raw}) : {16'b0, raw};
        if (raw[15])
            add_word(P_MINUS);
        if (cmd == CMD_NUMBER) begin
            say_count(mag);
            if (unit != 0)
                add_word((UNITS_BASE + unit - 1) & 7'h7f);
        end else begin
            hrs  = mag / 3600;
            mins = (mag % 3600) / 60;
            secs = mag % 60;
            if (hrs > 0) begin
                say_count(hrs);
                add_word(P_HOUR);
            end
            if (mins > 0) begin
                say_count(mins);
                add_word(P_MINUTE);
                if (secs > 0)
                    add_word(P_AND);
            end
            if (secs > 0) begin
                say_count(secs);
                add_word(P_SECOND);
            end
        end
        for (int k = 0; k < word_list.size(); k++) begin
            p.prompt = word_list[k];
            p.last   = (k == word_list.size() - 1);
            expected_prompts.push_back(p);
        end
    endfunction

    // ---------------------------------------------------------------- result side
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            pop <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_prompts
        t_prompt want;
        if (i_rst_n && pop && !empty) begin
            if (expected_prompts.size() == 0) begin
                $display("%0t unexpected prompt: expected none, actual %0d last %0b",
                         $time, o_prompt_index, o_last);
                errors++;
            end else begin
                want = expected_prompts.pop_front();
                prompts_checked++;
                if (o_prompt_index !== want.prompt) begin
                    $display("%0t prompt_index mismatch: expected %0d, actual %0d",
                             $time, want.prompt, o_prompt_index);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $display("%0t last mismatch: expected %0b, actual %0b",
                             $time, want.last, o_last);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- input side
    // Push stays high after a transfer; the next call or a drain decides its level.
    task automatic send_item(input bit cmd, input logic [15:0] val, input logic [3:0] unit);
        while ($urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_command   <= cmd;
        i_value     <= val;
        i_unit_code <= unit;
        @(posedge i_clk);
        while (full) begin
            full_stall_cycles++;
            @(posedge i_clk);
        end
        spell_item(cmd, val, unit);
        items_sent++;
    endtask

    // hold the input and wait out every pending prompt plus the pipeline depth
    task automatic wait_drain();
        push <= 1'b0;
        while (expected_prompts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_value();
        logic [15:0] v;
        case ($urandom_range(3))
            0: v = 16'($urandom);
            1: v = 16'($urandom_range(120));
            2: v = 16'($urandom_range(32) * 1000 + $urandom_range(2) * 100
                       + $urandom_range(1) * $urandom_range(99));
            default: v = 16'($urandom_range(9) * 3600 + $urandom_range(59) * 60
                             + $urandom_range(1) * $urandom_range(59));
        endcase
        if ($urandom_range(3) == 0)
            v = -v;
        return v;
    endfunction

    task automatic send_random();
        send_item(1'($urandom_range(1)), pick_value(), 4'($urandom_range(15)));
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_number_edges();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_item(CMD_NUMBER, 16'd0, 4'd0);
        send_item(CMD_NUMBER, 16'd19, 4'd1);
        send_item(CMD_NUMBER, 16'd20, 4'd0);
        send_item(CMD_NUMBER, 16'd99, 4'd15);
        send_item(CMD_NUMBER, 16'd100, 4'd0);
        send_item(CMD_NUMBER, 16'd199, 4'd0);
        send_item(CMD_NUMBER, 16'd200, 4'd3);
        send_item(CMD_NUMBER, 16'd1000, 4'd0);
        send_item(CMD_NUMBER, 16'd1100, 4'd0);
        send_item(CMD_NUMBER, 16'd1999, 4'd0);
        send_item(CMD_NUMBER, 16'd2000, 4'd0);
        send_item(CMD_NUMBER, 16'd32767, 4'd15);
        send_item(CMD_NUMBER, 16'hffff, 4'd0);
        send_item(CMD_NUMBER, 16'h8000, 4'd8);
        wait_drain();
    endtask

    task automatic test_duration_edges();
        send_item(CMD_DURATION, 16'd0, 4'd5);
        send_item(CMD_DURATION, 16'd1, 4'd0);
        send_item(CMD_DURATION, 16'd60, 4'd0);
        send_item(CMD_DURATION, 16'd61, 4'd0);
        send_item(CMD_DURATION, 16'd3600, 4'd0);
        send_item(CMD_DURATION, 16'd3661, 4'd15);
        send_item(CMD_DURATION, 16'd32767, 4'd0);
        send_item(CMD_DURATION, 16'hffff, 4'd0);
        send_item(CMD_DURATION, 16'h8000, 4'd0);
        send_item(CMD_DURATION, 16'h8000, 4'd0);
        send_item(CMD_DURATION, 16'd0, 4'd0);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count) send_random();
        wait_drain();
    endtask

    // stall the receiver for a long stretch so the input side reports full
    task automatic test_full_stall();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_left          = 300;
        repeat (30) send_random();
        wait_drain();
    endtask

    // pause the sender until everything has come out, then resume
    task automatic test_pause_and_resume();
        sender_idle_pct    = 21;
        receiver_stall_pct = 21;
        repeat (10) send_random();
        wait_drain();
        repeat (10) send_random();
        wait_drain();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_number_edges();
        test_duration_edges();
        test_random_traffic(99, 0, 0);
        test_random_traffic(99, 58, 0);
        test_random_traffic(99, 0, 58);
        test_random_traffic(99, 21, 21);
        test_full_stall();
        test_pause_and_resume();

        if (expected_prompts.size() != 0) begin
            $display("%0t %0d expected prompts never arrived", $time, expected_prompts.size());
            errors++;
        end
        $display("Covered %0d numbers and durations, %0d prompts checked, %0d cycles held off",
                 items_sent, prompts_checked, full_stall_cycles);
        $display("Idling mixes: none, sender, receiver, both; plus long hold-off and drains");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
